/* rtl/swhf_pkg.sv */
`default_nettype none

package swhf_pkg;

    localparam int SEQ_W      = 12;
    localparam int SEQ_SPACE  = 1 << SEQ_W;
    localparam int POS_W      = 32;
    localparam int CNT_W      = 16;
    localparam int FOLD_W     = 11;
    localparam int HITS_W     = 16;
    localparam int SPAN_W     = 32;
    localparam int HALF_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic OP_HIT    = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_HITS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SEQS = 2'd2;

    localparam logic [HALF_W-1:0] HALF_SEQS_RST = 12'd1;

    // one word of the per-sequence store
    typedef struct packed {
        logic             active;
        logic [CNT_W-1:0] count;
        logic [POS_W-1:0] first;
        logic [POS_W-1:0] last;
    } t_entry;

    typedef struct packed {
        logic              cand_valid;
        logic [FOLD_W-1:0] cand_seq;
        logic              overflow;
        logic              last;
    } t_result;

    typedef struct packed {
        logic             start;
        logic [SEQ_W-1:0] dividend;
        logic [SEQ_W-1:0] divisor;
    } t_fold_req;

    typedef struct packed {
        logic             done;
        logic [SEQ_W-1:0] rem;
    } t_fold_rsp;

endpackage

`default_nettype wire

/* rtl/swhf_ifs.sv */
`default_nettype none

interface swhf_in_if;
    import swhf_pkg::*;

    logic             valid;
    logic             ready;
    logic             operation;
    logic [SEQ_W-1:0] query_seq;
    logic [SEQ_W-1:0] hit_seq;
    logic [POS_W-1:0] word_pos;

    modport source (output valid, output operation, output query_seq, output hit_seq,
                    output word_pos, input ready);
    modport sink   (input valid, input operation, input query_seq, input hit_seq,
                    input word_pos, output ready);
endinterface

interface swhf_out_if;
    import swhf_pkg::*;

    logic              valid;
    logic              ready;
    logic              candidate_valid;
    logic [FOLD_W-1:0] candidate_seq;
    logic              list_overflow;
    logic              last;

    modport source (output valid, output candidate_valid, output candidate_seq,
                    output list_overflow, output last, input ready);
    modport sink   (input valid, input candidate_valid, input candidate_seq,
                    input list_overflow, input last, output ready);
endinterface

`default_nettype wire

/* rtl/swhf_fold.sv */
`default_nettype none

// Restoring remainder, one dividend bit per cycle. A zero divisor leaves the
// dividend untouched, which is the "no fold" case.
module swhf_fold (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire swhf_pkg::t_fold_req  i_req,
    output swhf_pkg::t_fold_rsp       o_rsp
);
    import swhf_pkg::*;

    localparam int STEP_W = $clog2(SEQ_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SEQ_W-1:0]  r_rem;
    logic [SEQ_W-1:0]  r_dvd;
    logic [SEQ_W-1:0]  r_div;
    logic [SEQ_W:0]    trial;
    logic [SEQ_W:0]    n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[SEQ_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = trial - {1'b0, r_div};
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(SEQ_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem[SEQ_W-1:0];
            r_dvd <= {r_dvd[SEQ_W-2:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

/* rtl/shared_word_hit_filter.sv */
// Shared-word hit filter.
// Input channel i_in carries words of two kinds: a hit (operation = 0) naming a
// sequence that shares a word with the query, and a finish (operation = 1).
// Output channel o_out carries candidate words; each finish yields one or more
// words, the final one marked by last. A finish with no candidate yields a single
// word with candidate_valid low. Registers are written through i_cfg_*; the
// user is to write them only while idle, which the block does not enforce.
// Hits are taken one per cycle while idle: a read-modify-write on the
// per-sequence memory (registered read, forwarding from the write of the
// previous cycle). A finish walks the touched list: each listed sequence gets
// a list read (S_LRD), a memory read (S_MRD) and an evaluate and clear step
// (S_EVAL); a passing one waits in S_FOLD for the remainder unit; S_PUSH loads
// each output word but the last, S_END the last. An empty list goes from S_LRD
// to S_END; no input is taken until the finish's last word is loaded. After
// reset the block sweeps all min(MAX_SEQS, 4096) memory entries with ready low;
// configuration writes are taken meanwhile. A stalled receiver holds the walk;
// one word waits in the output register and one each in r_pend_seq and r_fold.
`default_nettype none

module shared_word_hit_filter #(
    parameter int MAX_SEQS    = 4096,
    parameter int MATCH_DEPTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [swhf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [swhf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    swhf_in_if.sink                             i_in,
    swhf_out_if.source                          o_out
);
    import swhf_pkg::*;

    localparam int DEPTH = (MAX_SEQS < SEQ_SPACE) ? MAX_SEQS : SEQ_SPACE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MATCH_DEPTH + 1);
    localparam int LW    = (MATCH_DEPTH > 1) ? $clog2(MATCH_DEPTH) : 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LRD   = 3'd2;
    localparam logic [2:0] S_MRD   = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_FOLD  = 3'd5;
    localparam logic [2:0] S_PUSH  = 3'd6;
    localparam logic [2:0] S_END   = 3'd7;

    // configuration
    logic [HITS_W-1:0] r_min_hits;
    logic [SPAN_W-1:0] r_min_span;
    logic [HALF_W-1:0] r_half;

    // memories
    t_entry            seq_mem [DEPTH];
    logic [SEQ_W-1:0]  list_mem [MATCH_DEPTH];
    t_entry            r_m_rdata;
    logic [AW-1:0]     r_rd_addr;
    logic [AW-1:0]     rd_addr;
    logic [SEQ_W-1:0]  r_l_rdata;

    logic              we;
    logic [AW-1:0]     wr_addr;
    t_entry            wr_data;
    logic              r_w_valid;
    logic [AW-1:0]     r_w_addr;
    t_entry            r_w_data;

    // control
    logic [2:0]        r_state;
    logic [AW-1:0]     r_clr_addr;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_idx;
    logic              r_ovf;
    logic [SEQ_W-1:0]  r_query;
    logic [SEQ_W-1:0]  r_j;

    // hit stage B
    logic              r_b_valid;
    logic [SEQ_W-1:0]  r_b_seq;
    logic [POS_W-1:0]  r_b_pos;

    // results
    logic              r_pend_valid;
    logic [FOLD_W-1:0] r_pend_seq;
    logic [FOLD_W-1:0] r_fold;
    logic              r_out_valid;
    t_result           r_out;

    t_fold_req         fold_req;
    t_fold_rsp         fold_rsp;

    logic              in_acc;
    logic              hit_keep;
    t_entry            ent;
    t_entry            b_upd;
    logic              b_new;
    logic              b_drop;
    logic              e_pass;
    logic              out_free;
    logic              out_load;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && (r_state == S_IDLE);
    assign hit_keep   = (i_in.hit_seq >= i_in.query_seq) &&
                        (32'(i_in.hit_seq) < 32'(MAX_SEQS));
    assign out_free   = !r_out_valid || o_out.ready;
    assign out_load   = ((r_state == S_PUSH) || (r_state == S_END)) && out_free;

    // memory read port: input hit in idle, listed sequence during the walk
    assign rd_addr = (r_state == S_MRD) ? r_l_rdata[AW-1:0] : i_in.hit_seq[AW-1:0];

    always_ff @(posedge i_clk) begin
        r_m_rdata <= seq_mem[rd_addr];
        r_rd_addr <= rd_addr;
        if (we) begin
            seq_mem[wr_addr] <= wr_data;
        end
    end

    // the write at the same edge as the read is not seen by the read
    assign ent = (r_w_valid && (r_w_addr == r_rd_addr)) ? r_w_data : r_m_rdata;

    always_comb begin
        b_new        = !ent.active;
        b_drop       = b_new && (r_cnt == CW'(MATCH_DEPTH));
        b_upd.active = 1'b1;
        b_upd.count  = (ent.count == CNT_MAX) ? ent.count : ent.count + CNT_W'(1);
        b_upd.first  = b_new ? r_b_pos : ent.first;
        b_upd.last   = r_b_pos;
    end

    assign e_pass = (r_j > r_query) && (ent.count >= r_min_hits) &&
                    (ent.last >= ent.first) && ((ent.last - ent.first) >= r_min_span);

    always_comb begin
        we      = 1'b0;
        wr_addr = r_b_seq[AW-1:0];
        wr_data = b_upd;
        priority if (r_state == S_CLEAR) begin
            we      = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else if (r_state == S_EVAL) begin
            we      = 1'b1;
            wr_addr = r_j[AW-1:0];
            wr_data = '0;
        end else if (r_b_valid && !b_drop) begin
            we      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w_addr <= wr_addr;
        r_w_data <= wr_data;
        if (r_b_valid && b_new && !b_drop) begin
            list_mem[r_cnt[LW-1:0]] <= r_b_seq;
        end
        r_l_rdata <= list_mem[r_idx[LW-1:0]];
        r_b_seq   <= i_in.hit_seq;
        r_b_pos   <= i_in.word_pos;
    end

    assign fold_req.start    = (r_state == S_EVAL) && e_pass;
    assign fold_req.dividend = r_j;
    assign fold_req.divisor  = r_half;

    swhf_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fold_req),
        .o_rsp   (fold_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_hits <= '0;
            r_min_span <= '0;
            r_half     <= HALF_SEQS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MIN_HITS:  r_min_hits <= i_cfg_data[HITS_W-1:0];
                REG_MIN_SPAN:  r_min_span <= i_cfg_data[SPAN_W-1:0];
                REG_HALF_SEQS: r_half     <= i_cfg_data[HALF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_cnt        <= '0;
            r_idx        <= '0;
            r_ovf        <= 1'b0;
            r_b_valid    <= 1'b0;
            r_w_valid    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_w_valid <= we;
            r_b_valid <= in_acc && (i_in.operation == OP_HIT) && hit_keep;

            if (r_b_valid) begin
                if (b_drop) begin
                    r_ovf <= 1'b1;
                end else if (b_new) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc && (i_in.operation == OP_FINISH)) begin
                        r_query <= i_in.query_seq;
                        r_idx   <= '0;
                        r_state <= S_LRD;
                    end
                end
                S_LRD: begin
                    r_state <= (r_idx == r_cnt) ? S_END : S_MRD;
                end
                S_MRD: begin
                    r_j     <= r_l_rdata;
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (e_pass) begin
                        r_state <= S_FOLD;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_LRD;
                    end
                end
                S_FOLD: begin
                    if (fold_rsp.done) begin
                        if (r_pend_valid) begin
                            r_fold  <= fold_rsp.rem[FOLD_W-1:0];
                            r_state <= S_PUSH;
                        end else begin
                            r_pend_valid <= 1'b1;
                            r_pend_seq   <= fold_rsp.rem[FOLD_W-1:0];
                            r_idx        <= r_idx + CW'(1);
                            r_state      <= S_LRD;
                        end
                    end
                end
                S_PUSH: begin
                    if (out_free) begin
                        r_out.cand_valid <= 1'b1;
                        r_out.cand_seq   <= r_pend_seq;
                        r_out.overflow   <= r_ovf;
                        r_out.last       <= 1'b0;
                        r_pend_seq       <= r_fold;
                        r_idx            <= r_idx + CW'(1);
                        r_state          <= S_LRD;
                    end
                end
                S_END: begin
                    if (out_free) begin
                        r_out.cand_valid <= r_pend_valid;
                        r_out.cand_seq   <= r_pend_valid ? r_pend_seq : '0;
                        r_out.overflow   <= r_ovf;
                        r_out.last       <= 1'b1;
                        r_pend_valid     <= 1'b0;
                        r_cnt            <= '0;
                        r_ovf            <= 1'b0;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.candidate_valid = r_out.cand_valid;
    assign o_out.candidate_seq   = r_out.cand_seq;
    assign o_out.list_overflow   = r_out.overflow;
    assign o_out.last            = r_out.last;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none

module tb_top;
    import swhf_pkg::*;

    localparam int LIST_DEPTH   = 64;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 32;
    localparam int HOLDOFF_LEN  = 600;

    typedef struct packed {
        logic             op;
        logic [SEQ_W-1:0] query;
        logic [SEQ_W-1:0] seq;
        logic [POS_W-1:0] pos;
    } t_filter_word;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    swhf_in_if  in_if ();
    swhf_out_if out_if ();

    shared_word_hit_filter #(
        .MAX_SEQS    (SEQ_SPACE),
        .MATCH_DEPTH (LIST_DEPTH)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #6 clk = ~clk;

    // filter state as the block should hold it
    logic [HITS_W-1:0] cfg_min_hits = '0;
    logic [SPAN_W-1:0] cfg_min_span = '0;
    logic [HALF_W-1:0] cfg_half     = HALF_SEQS_RST;

    logic [CNT_W-1:0]  hits_tbl  [SEQ_SPACE];
    logic [POS_W-1:0]  first_tbl [SEQ_SPACE];
    logic [POS_W-1:0]  last_tbl  [SEQ_SPACE];
    bit                live_tbl  [SEQ_SPACE];
    logic [SEQ_W-1:0]  touch_order [$];
    bit                drop_seen;

    t_filter_word pending_words [$];
    t_result      expected_cands [$];
    t_filter_word cur_word;

    int burst_left = 0;
    int gap_left   = 0;

    t_rx_mode stall_mode = RX_OPEN;
    int  mode_left    = 0;
    int  holdoff_left = 0;
    bit  holdoff_done = 1'b0;

    int words_seen     = 0;
    int mismatch_count = 0;
    int hits_sent      = 0;
    int finishes_sent  = 0;
    int cands_seen     = 0;
    int ovf_seen       = 0;
    int idle_run       = 0;

    initial begin
        foreach (hits_tbl[k]) begin
            hits_tbl[k] = '0;
            live_tbl[k] = 1'b0;
        end
        drop_seen = 1'b0;
    end

    function automatic void apply_hit(logic [SEQ_W-1:0] query, logic [SEQ_W-1:0] seq,
                                      logic [POS_W-1:0] pos);
        if (seq < query)
            return;
        if (!live_tbl[seq]) begin
            if (touch_order.size() >= LIST_DEPTH) begin
                drop_seen = 1'b1;
                return;
            end
            touch_order.push_back(seq);
            live_tbl[seq]  = 1'b1;
            first_tbl[seq] = pos;
        end
        last_tbl[seq] = pos;
        if (hits_tbl[seq] != CNT_MAX)
            hits_tbl[seq]++;
    endfunction

    // walk the touched list, queue the candidate words, clear the entries
    function automatic void close_query(logic [SEQ_W-1:0] query);
        t_result          outs [$];
        t_result          r;
        logic [SEQ_W-1:0] j;
        int               folded;
        bit               pass;
        foreach (touch_order[k]) begin
            j = touch_order[k];
            pass = (j > query) && (hits_tbl[j] >= cfg_min_hits) &&
                   (last_tbl[j] >= first_tbl[j]) &&
                   (last_tbl[j] - first_tbl[j] >= cfg_min_span);
            if (pass) begin
                folded       = (cfg_half != 0) ? int'(j) % int'(cfg_half) : int'(j);
                r.cand_valid = 1'b1;
                r.cand_seq   = folded[FOLD_W-1:0];
                r.overflow   = drop_seen;
                r.last       = 1'b0;
                outs.push_back(r);
            end
            hits_tbl[j] = '0;
            live_tbl[j] = 1'b0;
        end
        if (outs.size() == 0) begin
            r.cand_valid = 1'b0;
            r.cand_seq   = '0;
            r.overflow   = drop_seen;
            r.last       = 1'b1;
            outs.push_back(r);
        end else begin
            outs[outs.size()-1].last = 1'b1;
        end
        foreach (outs[k])
            expected_cands.push_back(outs[k]);
        touch_order.delete();
        drop_seen = 1'b0;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < 50)
            $display("mismatch at word %0d: %s", words_seen, msg);
        mismatch_count++;
    endtask

    task automatic check_cand();
        t_result want;
        if (expected_cands.size() == 0) begin
            report_mismatch("candidate word with nothing expected");
            return;
        end
        want = expected_cands.pop_front();
        if (out_if.candidate_valid !== want.cand_valid)
            report_mismatch($sformatf("candidate_valid %b, expected %b",
                                      out_if.candidate_valid, want.cand_valid));
        if (out_if.candidate_seq !== want.cand_seq)
            report_mismatch($sformatf("candidate_seq %0d, expected %0d",
                                      out_if.candidate_seq, want.cand_seq));
        if (out_if.list_overflow !== want.overflow)
            report_mismatch($sformatf("list_overflow %b, expected %b",
                                      out_if.list_overflow, want.overflow));
        if (out_if.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", out_if.last, want.last));
        if (want.cand_valid)
            cands_seen++;
        if (want.overflow)
            ovf_seen++;
    endtask

    // sender: bursts of random length with gaps, fed from pending_words
    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                if (cur_word.op == OP_HIT) begin
                    apply_hit(cur_word.query, cur_word.seq, cur_word.pos);
                    hits_sent++;
                end else begin
                    close_query(cur_word.query);
                    finishes_sent++;
                end
            end
            if (!(in_if.valid && !in_if.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    cur_word = pending_words.pop_front();
                    in_if.valid     <= 1'b1;
                    in_if.operation <= cur_word.op;
                    in_if.query_seq <= cur_word.query;
                    in_if.hit_seq   <= cur_word.seq;
                    in_if.word_pos  <= cur_word.pos;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 16);
                        gap_left   = $urandom_range(1, 6);
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks words and stalls on its own pattern, with one long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                check_cand();
                words_seen++;
            end
            if (!holdoff_done && words_seen >= 12) begin
                holdoff_left = HOLDOFF_LEN;
                holdoff_done = 1'b1;
            end
            if (mode_left == 0) begin
                stall_mode = t_rx_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 120);
            end else begin
                mode_left--;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                out_if.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    RX_OPEN:   out_if.ready <= 1'b1;
                    RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_if.ready <= ($urandom_range(0, 4) == 0);
                    default:   out_if.ready <= (mode_left[2] == 1'b0);
                endcase
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_MIN_HITS:  cfg_min_hits = data[HITS_W-1:0];
            REG_MIN_SPAN:  cfg_min_span = data[SPAN_W-1:0];
            REG_HALF_SEQS: cfg_half     = data[HALF_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_filter(int unsigned hits, int unsigned span, int unsigned half);
        write_reg(REG_MIN_HITS, hits);
        write_reg(REG_MIN_SPAN, span);
        write_reg(REG_HALF_SEQS, half);
    endtask

    task automatic push_hit(int q, int s, logic [POS_W-1:0] p);
        t_filter_word w;
        w.op    = OP_HIT;
        w.query = q[SEQ_W-1:0];
        w.seq   = s[SEQ_W-1:0];
        w.pos   = p;
        pending_words.push_back(w);
    endtask

    task automatic push_finish(int q);
        t_filter_word w;
        w.op    = OP_FINISH;
        w.query = q[SEQ_W-1:0];
        w.seq   = SEQ_W'($urandom_range(0, SEQ_SPACE - 1));
        w.pos   = $urandom();
        pending_words.push_back(w);
    endtask

    // all words taken, all candidates back, then let the block settle
    task automatic wait_idle();
        while (pending_words.size() != 0 || in_if.valid || expected_cands.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one query = a run of hits mostly on a small pool above the query, then a finish
    task automatic add_random_queries(int target);
        int               added;
        int               q;
        int               npool;
        int               nhits;
        int               nflood;
        int               pool [8];
        int               s;
        int               r;
        int               hq;
        logic [POS_W-1:0] pos;
        added = 0;
        while (added < target) begin
            q     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SEQ_SPACE - 1)
                                                : $urandom_range(0, 3800);
            npool = $urandom_range(1, 8);
            for (int k = 0; k < npool; k++)
                pool[k] = $urandom_range(q, (q + 300 > SEQ_SPACE - 1) ? SEQ_SPACE - 1 : q + 300);
            nhits = $urandom_range(1, 24);
            pos   = $urandom();
            for (int h = 0; h < nhits; h++) begin
                r = $urandom_range(0, 19);
                if (r < 14)
                    s = pool[$urandom_range(0, npool - 1)];
                else if (r < 16)
                    s = q;
                else if (r < 18)
                    s = $urandom_range(0, SEQ_SPACE - 1);
                else
                    s = (q == 0) ? 0 : $urandom_range(0, q - 1);
                hq = ($urandom_range(0, 24) == 0) ? $urandom_range(0, SEQ_SPACE - 1) : q;
                if ($urandom_range(0, 9) == 0)
                    pos = $urandom();
                else
                    pos += $urandom_range(0, 400);
                push_hit(hq, s, pos);
            end
            added += nhits + 1;
            // now and then touch at least as many sequences as the list can hold
            if ($urandom_range(0, 9) == 0 && q <= 3900) begin
                nflood = $urandom_range(LIST_DEPTH, LIST_DEPTH + 16);
                for (int k = 0; k < nflood; k++)
                    push_hit(q, q + k, pos + k);
                added += nflood;
            end
            push_finish(($urandom_range(0, 9) == 0) ? $urandom_range(0, SEQ_SPACE - 1) : q);
        end
    endtask

    initial begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_if.valid     = 1'b0;
        in_if.operation = OP_HIT;
        in_if.query_seq = '0;
        in_if.hit_seq   = '0;
        in_if.word_pos  = '0;
        out_if.ready    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: no fold, two hits and a span of five needed
        set_filter(2, 5, 0);
        push_hit(100, 99, 10);              // below the query
        push_hit(100, 100, 0);              // the query itself
        push_hit(100, 100, 50);
        push_hit(100, 4095, 0);
        push_hit(100, 4095, 32'hFFFF_FFFF); // wide id, masked to 11 bits
        push_hit(100, 200, 1000);
        push_hit(100, 200, 3);              // span goes backwards
        push_hit(100, 300, 7);
        push_hit(100, 300, 12);             // span exactly at threshold
        push_hit(100, 301, 7);
        push_hit(100, 301, 11);
        push_hit(100, 302, 0);
        push_hit(0, 150, 0);                // hit filtered by its own query
        push_hit(0, 150, 100);
        push_finish(160);                   // finish compares against its own query
        push_finish(4095);                  // empty list
        push_hit(4095, 4095, 5);
        push_hit(4095, 4095, 9);
        push_finish(4094);
        wait_idle();

        // directed: widest span, fold by 4095, no hit minimum
        set_filter(0, 32'hFFFF_FFFF, 4095);
        push_hit(0, 4095, 0);
        push_hit(0, 4095, 32'hFFFF_FFFF);
        push_hit(0, 4000, 1);
        push_hit(0, 4000, 32'hFFFF_FFFF);
        push_hit(0, 0, 0);
        push_finish(0);
        wait_idle();

        set_filter(1, 0, 2048);
        add_random_queries(65);
        wait_idle();
        set_filter(3, 64, 1000);
        add_random_queries(65);
        wait_idle();
        set_filter(0, 0, 4095);
        add_random_queries(65);
        wait_idle();
        set_filter(2, 600, 1);
        add_random_queries(65);
        wait_idle();
        set_filter(int'(CNT_MAX), 0, 0);
        add_random_queries(65);
        wait_idle();
        set_filter($urandom_range(0, 5), $urandom_range(0, 300), $urandom_range(0, 4095));
        add_random_queries(65);
        wait_idle();

        if (expected_cands.size() != 0)
            report_mismatch($sformatf("%0d candidate words never arrived",
                                      expected_cands.size()));
        $display("covered %0d hits and %0d finishes under 8 filter settings",
                 hits_sent, finishes_sent);
        $display("checked %0d output words: %0d candidates, %0d with list overflow",
                 words_seen, cands_seen, ovf_seen);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
